// File: rtl/core/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg: shared types and constants of the pulse-width one-wire link
// Holds the link modes, the register map and the item, result and
// configuration records.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [15:0] SHORT_RST   = 16'd16;
  localparam logic [15:0] LONG_RST    = 16'd48;
  localparam logic [15:0] SAMPLE_RST  = 16'd32;
  localparam logic [19:0] TIMEOUT_RST = 20'd480000;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SEND  = 2'd1;
  localparam logic [1:0] ACT_RECV  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum logic [1:0] {
    REG_SHORT   = 2'd0,
    REG_LONG    = 2'd1,
    REG_SAMPLE  = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic [9:0] {
    M_IDLE         = 10'b0000000001,
    M_TX_LOW       = 10'b0000000010,
    M_TX_HIGH      = 10'b0000000100,
    M_TX_GAP       = 10'b0000001000,
    M_TX_STOP      = 10'b0000010000,
    M_RX_FALL      = 10'b0000100000,
    M_RX_DELAY     = 10'b0001000000,
    M_RX_RISE      = 10'b0010000000,
    M_RX_STOP_FALL = 10'b0100000000,
    M_RX_STOP_RISE = 10'b1000000000
  } mode_t;

  typedef struct packed {
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] sample_delay_ticks;
    logic [19:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [6:0] rx_length;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       line_pull_low;
    logic       byte_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       frame_done;
    logic       timed_out;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/pwl_in_if.sv
// ----------------------------------------------------------------------------
// pwl_in_if: tick channel into the link
// One transaction per line sample, with the action and its arguments.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [6:0] rx_length;
  logic       line_in;

  modport source (output valid, action, tx_byte, tx_last, rx_length, line_in,
                  input ready);
  modport sink   (input valid, action, tx_byte, tx_last, rx_length, line_in,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/pwl_out_if.sv
// ----------------------------------------------------------------------------
// pwl_out_if: result channel out of the link
// One transaction per tick with line drive, receive data and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwl_out_if;
  logic       valid;
  logic       ready;
  logic       line_pull_low;
  logic       byte_taken;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_last;
  logic       frame_done;
  logic       timed_out;
  logic       busy_res;

  modport source (output valid, line_pull_low, byte_taken, rx_valid, rx_byte,
                  rx_last, frame_done, timed_out, busy_res,
                  input ready);
  modport sink   (input valid, line_pull_low, byte_taken, rx_valid, rx_byte,
                  rx_last, frame_done, timed_out, busy_res,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/pwl_regs.sv
// ----------------------------------------------------------------------------
// pwl_regs: APB configuration registers
// Phase lengths, sample delay and receive timeout, one word each.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pwl_pkg::CFG_AW-1:0] paddr,
  input  wire logic [pwl_pkg::CFG_DW-1:0] pwdata,
  output logic      [pwl_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output pwl_pkg::cfg_t                   cfg
);
  import pwl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SHORT:   cfg_nxt.short_ticks        = pwdata[15:0];
        REG_LONG:    cfg_nxt.long_ticks         = pwdata[15:0];
        REG_SAMPLE:  cfg_nxt.sample_delay_ticks = pwdata[15:0];
        REG_TIMEOUT: cfg_nxt.timeout_ticks      = pwdata[19:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHORT:   prdata = {16'd0, cfg_r.short_ticks};
      REG_LONG:    prdata = {16'd0, cfg_r.long_ticks};
      REG_SAMPLE:  prdata = {16'd0, cfg_r.sample_delay_ticks};
      REG_TIMEOUT: prdata = {12'd0, cfg_r.timeout_ticks};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks        <= SHORT_RST;
      cfg_r.long_ticks         <= LONG_RST;
      cfg_r.sample_delay_ticks <= SAMPLE_RST;
      cfg_r.timeout_ticks      <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/pwl_link.sv
// ----------------------------------------------------------------------------
// pwl_link: link state machine
// Advances the send/receive machine by one tick per committed item and
// forms that tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_link #(
  parameter int MAX_RX_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire pwl_pkg::item_t    item,
  input  wire pwl_pkg::cfg_t     cfg,
  output pwl_pkg::result_t       res
);
  import pwl_pkg::*;

  localparam logic [7:0] MAX_B   = 8'(MAX_RX_BYTES);
  localparam logic [6:0] MAX_SAT = (MAX_RX_BYTES > 127) ? 7'd127 : 7'(MAX_RX_BYTES);

  mode_t       mode_r,  mode_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [2:0]  bitpos_r, bitpos_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        hfull_r, hfull_nxt;
  logic        hlast_r, hlast_nxt;
  logic        clast_r, clast_nxt;
  logic [6:0]  remain_r, remain_nxt;
  logic [19:0] tmo_r, tmo_nxt;

  logic        in_rx;
  logic        ph_over;
  logic [15:0] ph_dec;
  logic [20:0] tmo_inc;
  logic [6:0]  rx_len_sat;

  assign in_rx = (mode_r == M_RX_FALL) || (mode_r == M_RX_DELAY) ||
                 (mode_r == M_RX_RISE) || (mode_r == M_RX_STOP_FALL) ||
                 (mode_r == M_RX_STOP_RISE);
  assign ph_over    = (phase_r <= 16'd1);
  assign ph_dec     = phase_r - 16'd1;
  assign tmo_inc    = {1'b0, tmo_r} + 21'd1;
  assign rx_len_sat = ({1'b0, item.rx_length} > MAX_B) ? MAX_SAT : item.rx_length;

  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    bitpos_nxt = bitpos_r;
    shift_nxt  = shift_r;
    hold_nxt   = hold_r;
    hfull_nxt  = hfull_r;
    hlast_nxt  = hlast_r;
    clast_nxt  = clast_r;
    remain_nxt = remain_r;
    tmo_nxt    = tmo_r;
    res        = '0;

    res.line_pull_low = (mode_r == M_TX_LOW) || (mode_r == M_TX_STOP);

    if (in_rx) begin
      if (tmo_inc >= {1'b0, cfg.timeout_ticks}) begin
        res.timed_out = 1'b1;
        mode_nxt      = M_IDLE;
        tmo_nxt       = '0;
      end else begin
        tmo_nxt = tmo_inc[19:0];
      end
    end

    unique case (mode_nxt)
      M_IDLE, M_TX_GAP: begin
        if (hfull_r) begin
          shift_nxt  = hold_r;
          clast_nxt  = hlast_r;
          hfull_nxt  = 1'b0;
          bitpos_nxt = '0;
          mode_nxt   = M_TX_LOW;
          phase_nxt  = hold_r[7] ? cfg.short_ticks : cfg.long_ticks;
        end
      end
      M_TX_LOW: begin
        if (ph_over) begin
          mode_nxt  = M_TX_HIGH;
          phase_nxt = shift_r[7] ? cfg.long_ticks : cfg.short_ticks;
        end else begin
          phase_nxt = ph_dec;
        end
      end
      M_TX_HIGH: begin
        if (ph_over) begin
          shift_nxt  = {shift_r[6:0], 1'b0};
          bitpos_nxt = bitpos_r + 3'd1;
          if (bitpos_nxt != 3'd0) begin
            mode_nxt  = M_TX_LOW;
            phase_nxt = shift_r[6] ? cfg.short_ticks : cfg.long_ticks;
          end else if (clast_r) begin
            mode_nxt  = M_TX_STOP;
            phase_nxt = cfg.short_ticks;
          end else if (hfull_r) begin
            shift_nxt  = hold_r;
            clast_nxt  = hlast_r;
            hfull_nxt  = 1'b0;
            bitpos_nxt = '0;
            mode_nxt   = M_TX_LOW;
            phase_nxt  = hold_r[7] ? cfg.short_ticks : cfg.long_ticks;
          end else begin
            mode_nxt = M_TX_GAP;
          end
        end else begin
          phase_nxt = ph_dec;
        end
      end
      M_TX_STOP: begin
        if (ph_over) begin
          res.frame_done = 1'b1;
          clast_nxt      = 1'b0;
          mode_nxt       = M_IDLE;
        end else begin
          phase_nxt = ph_dec;
        end
      end
      M_RX_FALL: begin
        if (!item.line_in) begin
          mode_nxt  = M_RX_DELAY;
          phase_nxt = cfg.sample_delay_ticks;
        end
      end
      M_RX_DELAY: begin
        if (ph_over) begin
          shift_nxt  = {shift_r[6:0], item.line_in};
          bitpos_nxt = bitpos_r + 3'd1;
          mode_nxt   = M_RX_RISE;
        end else begin
          phase_nxt = ph_dec;
        end
      end
      M_RX_RISE: begin
        if (item.line_in) begin
          if (bitpos_r == 3'd0) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = shift_r;
            res.rx_last  = (remain_r <= 7'd1);
            remain_nxt   = (remain_r != 7'd0) ? remain_r - 7'd1 : 7'd0;
            shift_nxt    = '0;
            mode_nxt     = (remain_nxt != 7'd0) ? M_RX_FALL : M_RX_STOP_FALL;
          end else begin
            mode_nxt = M_RX_FALL;
          end
        end
      end
      M_RX_STOP_FALL: begin
        if (!item.line_in) mode_nxt = M_RX_STOP_RISE;
      end
      M_RX_STOP_RISE: begin
        if (item.line_in) begin
          res.frame_done = 1'b1;
          mode_nxt       = M_IDLE;
          tmo_nxt        = '0;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    // offers go to the hold register; a receive start needs a quiet link
    if (item.action == ACT_SEND && (mode_nxt == M_IDLE || mode_nxt == M_TX_LOW ||
        mode_nxt == M_TX_HIGH || mode_nxt == M_TX_GAP || mode_nxt == M_TX_STOP) &&
        !hfull_nxt) begin
      hold_nxt       = item.tx_byte;
      hlast_nxt      = item.tx_last;
      hfull_nxt      = 1'b1;
      res.byte_taken = 1'b1;
    end else if (item.action == ACT_RECV && mode_nxt == M_IDLE && !hfull_nxt) begin
      remain_nxt = rx_len_sat;
      tmo_nxt    = '0;
      shift_nxt  = '0;
      bitpos_nxt = '0;
      mode_nxt   = (rx_len_sat != 7'd0) ? M_RX_FALL : M_RX_STOP_FALL;
    end

    res.busy_res = (mode_nxt != M_IDLE) || hfull_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      phase_r  <= '0;
      bitpos_r <= '0;
      shift_r  <= '0;
      hold_r   <= '0;
      hfull_r  <= 1'b0;
      hlast_r  <= 1'b0;
      clast_r  <= 1'b0;
      remain_r <= '0;
      tmo_r    <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      bitpos_r <= bitpos_nxt;
      shift_r  <= shift_nxt;
      hold_r   <= hold_nxt;
      hfull_r  <= hfull_nxt;
      hlast_r  <= hlast_nxt;
      clast_r  <= clast_nxt;
      remain_r <= remain_nxt;
      tmo_r    <= tmo_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pulse_width_one_wire_link_unit.sv
// ----------------------------------------------------------------------------
// pulse_width_one_wire_link_unit: half-duplex pulse-width serial link
// Each input transaction is one tick of the line: it carries the sampled
// line level and an optional action (offer a send byte, start a receive).
// Each tick yields exactly one result transaction: the line drive for that
// tick, whether the offered byte was taken, a received byte with its last
// flag, stop-bit and timeout status, and the busy flag.
// Phase lengths, sample delay and receive timeout sit in an APB register
// bank (byte addresses 0, 4, 8, 12); write them only while the link is idle.
// The tick is registered, the link machine steps once from that register,
// and the result is registered. Throughput is one tick per cycle while the
// result side does not stall, set by the single step of the link machine
// between the tick and result registers.
// A stalled result register holds; one more tick is taken into the input
// register, after which in_ch.ready drops until the result is accepted.
// Synchronous reset returns the link to idle, empties both registers and
// restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_one_wire_link_unit #(
  parameter int MAX_RX_BYTES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pwl_in_if.sink                          in_ch,
  pwl_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pwl_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pwl_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [pwl_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pwl_pkg::*;

  cfg_t    cfg;
  item_t   s0_r;
  logic    s0_valid_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    step_en;
  logic    in_fire;

  pwl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // advance the link when a tick is held and the result slot is free or being emptied
  assign step_en      = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s0_valid_r || step_en;
  assign in_fire      = in_ch.valid && in_ch.ready;

  pwl_link #(
    .MAX_RX_BYTES (MAX_RX_BYTES)
  ) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s0_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_r.action    <= in_ch.action;
      s0_r.tx_byte   <= in_ch.tx_byte;
      s0_r.tx_last   <= in_ch.tx_last;
      s0_r.rx_length <= in_ch.rx_length;
      s0_r.line_in   <= in_ch.line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) out_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.line_pull_low = out_r.line_pull_low;
  assign out_ch.byte_taken    = out_r.byte_taken;
  assign out_ch.rx_valid      = out_r.rx_valid;
  assign out_ch.rx_byte       = out_r.rx_byte;
  assign out_ch.rx_last       = out_r.rx_last;
  assign out_ch.frame_done    = out_r.frame_done;
  assign out_ch.timed_out     = out_r.timed_out;
  assign out_ch.busy_res      = out_r.busy_res;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_out_from_s0: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s0_valid_r))
    else $error("result appeared without a registered tick");

  a_take_vs_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.byte_taken && out_r.rx_valid))
    else $error("send byte taken in a receive tick");

  a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.timed_out) |-> (!out_r.rx_valid && !out_r.frame_done))
    else $error("timeout tick also reports receive progress");

endmodule

`default_nettype wire

// File: tb/sv/tb_pulse_width_one_wire_link_unit.sv
// ----------------------------------------------------------------------------
// tb_pulse_width_one_wire_link_unit: self-checking bench of the pulse-width link
// Drives line ticks through the input channel, mimics a replying device on
// the sampled line, programs the APB registers between phases and compares
// every result transaction with an in-bench model of the link machine.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pulse_width_one_wire_link_unit;
  import pwl_pkg::*;

  localparam int MAX_RX         = 64;
  localparam int MAX_SHOWN      = 10;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT    = 4000;

  class link_scoreboard;
    logic [15:0] short_len, long_len, sample_len;
    logic [19:0] abort_len;
    mode_t       mode;
    logic [15:0] phase_cnt;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg, held;
    bit          held_full, held_last, sending_last, last_taken;
    logic [6:0]  left;
    logic [19:0] abort_cnt;
    result_t     due_results[$];
    int          errors;

    function new();
      short_len  = SHORT_RST;
      long_len   = LONG_RST;
      sample_len = SAMPLE_RST;
      abort_len  = TIMEOUT_RST;
      mode       = M_IDLE;
      phase_cnt  = '0;
      bit_idx    = '0;
      shreg      = '0;
      held       = '0;
      held_full  = 1'b0;
      held_last  = 1'b0;
      sending_last = 1'b0;
      last_taken = 1'b0;
      left       = '0;
      abort_cnt  = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_SHORT:   short_len  = value[15:0];
        REG_LONG:    long_len   = value[15:0];
        REG_SAMPLE:  sample_len = value[15:0];
        REG_TIMEOUT: abort_len  = value[19:0];
        default: ;
      endcase
    endfunction

    function bit receiving();
      case (mode)
        M_RX_FALL, M_RX_DELAY, M_RX_RISE, M_RX_STOP_FALL, M_RX_STOP_RISE: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit busy();
      return (mode != M_IDLE) || held_full;
    endfunction

    // frame left open after a byte that was not marked last
    function bit gap_open();
      return (mode == M_TX_GAP) && !held_full;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit phase_done();
      if (phase_cnt <= 16'd1) return 1'b1;
      phase_cnt = phase_cnt - 16'd1;
      return 1'b0;
    endfunction

    function void begin_bit();
      mode = M_TX_LOW;
      phase_cnt = shreg[7] ? short_len : long_len;
    endfunction

    function void load_held();
      shreg = held;
      sending_last = held_last;
      held_full = 1'b0;
      bit_idx = '0;
      begin_bit();
    endfunction

    // advance the link by one tick and queue the result it must produce
    function void take_tick(item_t it);
      result_t r;
      int      n;
      r = '0;
      r.line_pull_low = (mode == M_TX_LOW) || (mode == M_TX_STOP);
      if (receiving()) begin
        if (int'(abort_cnt) + 1 >= int'(abort_len)) begin
          r.timed_out = 1'b1;
          mode = M_IDLE;
          abort_cnt = '0;
        end else begin
          abort_cnt = abort_cnt + 20'd1;
        end
      end
      case (mode)
        M_IDLE, M_TX_GAP: if (held_full) load_held();
        M_TX_LOW: if (phase_done()) begin
          mode = M_TX_HIGH;
          phase_cnt = shreg[7] ? long_len : short_len;
        end
        M_TX_HIGH: if (phase_done()) begin
          shreg = shreg << 1;
          bit_idx = bit_idx + 3'd1;
          if (bit_idx != 3'd0) begin
            begin_bit();
          end else if (sending_last) begin
            mode = M_TX_STOP;
            phase_cnt = short_len;
          end else if (held_full) begin
            load_held();
          end else begin
            mode = M_TX_GAP;
          end
        end
        M_TX_STOP: if (phase_done()) begin
          r.frame_done = 1'b1;
          sending_last = 1'b0;
          mode = M_IDLE;
        end
        M_RX_FALL: if (!it.line_in) begin
          mode = M_RX_DELAY;
          phase_cnt = sample_len;
        end
        M_RX_DELAY: if (phase_done()) begin
          shreg = {shreg[6:0], it.line_in};
          bit_idx = bit_idx + 3'd1;
          mode = M_RX_RISE;
        end
        M_RX_RISE: if (it.line_in) begin
          if (bit_idx == 3'd0) begin
            r.rx_valid = 1'b1;
            r.rx_byte = shreg;
            r.rx_last = (left <= 7'd1);
            if (left != 7'd0) left = left - 7'd1;
            shreg = '0;
            mode = (left != 7'd0) ? M_RX_FALL : M_RX_STOP_FALL;
          end else begin
            mode = M_RX_FALL;
          end
        end
        M_RX_STOP_FALL: if (!it.line_in) mode = M_RX_STOP_RISE;
        M_RX_STOP_RISE: if (it.line_in) begin
          r.frame_done = 1'b1;
          mode = M_IDLE;
          abort_cnt = '0;
        end
        default: mode = M_IDLE;
      endcase

      if (it.action == ACT_SEND && !receiving() && !held_full) begin
        held = it.tx_byte;
        held_last = it.tx_last;
        held_full = 1'b1;
        r.byte_taken = 1'b1;
      end else if (it.action == ACT_RECV && mode == M_IDLE && !held_full) begin
        n = (int'(it.rx_length) > MAX_RX) ? MAX_RX : int'(it.rx_length);
        left = n[6:0];
        abort_cnt = '0;
        shreg = '0;
        bit_idx = '0;
        mode = (left != 7'd0) ? M_RX_FALL : M_RX_STOP_FALL;
      end
      r.busy_res = busy();
      last_taken = r.byte_taken;
      due_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("pull=%b taken=%b rxv=%b byte=%h last=%b done=%b tmo=%b busy=%b",
                       r.line_pull_low, r.byte_taken, r.rx_valid, r.rx_byte, r.rx_last,
                       r.frame_done, r.timed_out, r.busy_res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        if (errors < MAX_SHOWN) $display("unexpected result transaction: %s", show(got));
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        if (errors < MAX_SHOWN) begin
          $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata, cfg_prdata;

  pwl_in_if  in_ch ();
  pwl_out_if out_ch ();

  pulse_width_one_wire_link_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  link_scoreboard sb;
  int  src_idle_pct;
  int  snk_stall_pct;
  int  ticks_sent;
  int  quiet;
  bit  hold_req;
  bit  inject_on;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= !($urandom_range(99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.line_pull_low, out_ch.byte_taken, out_ch.rx_valid,
                       out_ch.rx_byte, out_ch.rx_last, out_ch.frame_done,
                       out_ch.timed_out, out_ch.busy_res});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t make_item(logic [1:0] action, logic [7:0] txb, logic txl,
                                      logic [6:0] len, logic line);
    item_t it;
    it.action = action;
    it.tx_byte = txb;
    it.tx_last = txl;
    it.rx_length = len;
    it.line_in = line;
    return it;
  endfunction

  task automatic drive_tick(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.tx_byte   <= it.tx_byte;
    in_ch.tx_last   <= it.tx_last;
    in_ch.rx_length <= it.rx_length;
    in_ch.line_in   <= it.line_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_tick(it);
    ticks_sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_link(logic [15:0] s, logic [15:0] l, logic [15:0] d,
                              logic [19:0] t);
    write_reg(REG_SHORT, 32'(s));
    write_reg(REG_LONG, 32'(l));
    write_reg(REG_SAMPLE, 32'(d));
    write_reg(REG_TIMEOUT, 32'(t));
  endtask

  // hold the line at one level; now and then slip in a stray offer or start
  task automatic run_line(logic level, int n);
    item_t it;
    repeat (n) begin
      it = make_item(ACT_TICK, 8'($urandom), 1'($urandom), 7'($urandom), level);
      if (inject_on && $urandom_range(99) < 3) begin
        it.action = $urandom_range(1) ? ACT_SEND : ACT_RECV;
      end
      drive_tick(it);
    end
  endtask

  // run ticks until the link is idle: close open frames, toggle the line
  task automatic settle_link();
    item_t it;
    logic  lvl;
    lvl = 1'b0;
    while (sb.busy()) begin
      it = make_item(ACT_TICK, 8'($urandom), 1'b1, 7'($urandom), lvl);
      if (sb.gap_open()) it.action = ACT_SEND;
      lvl = !lvl;
      drive_tick(it);
    end
  endtask

  // stop offering until every result is back, then let the pipeline empty
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // device reply: per bit a low then a high, sized around the sample point
  task automatic answer(int n_bytes);
    logic [7:0] b;
    int         sd, lo, hi;
    sd = (sb.sample_len == 16'd0) ? 1 : int'(sb.sample_len);
    repeat (n_bytes) begin
      b = 8'($urandom);
      for (int i = 7; i >= 0; i--) begin
        if (b[i]) begin
          lo = $urandom_range(sd, 1);
          hi = sd - lo + 2 + $urandom_range(2);
        end else begin
          lo = sd + 1 + $urandom_range(2);
          hi = 1 + $urandom_range(2);
        end
        run_line(1'b0, lo);
        run_line(1'b1, hi);
      end
    end
    run_line(1'b0, 1 + $urandom_range(2));
    run_line(1'b1, 1 + $urandom_range(3));
  endtask

  task automatic receive_reply();
    int n;
    settle_link();
    n = ($urandom_range(99) < 5) ? $urandom_range(127) : $urandom_range(4);
    drive_tick(make_item(ACT_RECV, 8'($urandom), 1'($urandom), 7'(n), 1'b1));
    answer((n > MAX_RX) ? MAX_RX : n);
  endtask

  task automatic broken_receive();
    settle_link();
    drive_tick(make_item(ACT_RECV, 8'($urandom), 1'($urandom), 7'($urandom), 1'b1));
    repeat ($urandom_range(40, 3)) begin
      drive_tick(make_item(ACT_TICK, 8'($urandom), 1'($urandom), 7'($urandom),
                           1'($urandom)));
    end
  endtask

  task automatic send_frame();
    item_t it;
    int    nb;
    bit    underrun;
    nb = $urandom_range(4, 1);
    underrun = ($urandom_range(99) < 12);
    for (int k = 0; k < nb; k++) begin
      it = make_item(ACT_SEND, 8'($urandom), (k == nb - 1) && !underrun,
                     7'($urandom), 1'($urandom));
      drive_tick(it);
      // re-offer the same byte until the hold register takes it
      while (!sb.last_taken) drive_tick(it);
    end
    run_line(1'b1, $urandom_range(8));
  endtask

  task automatic noise(bit allow_send);
    item_t it;
    repeat ($urandom_range(25, 5)) begin
      it = make_item(2'($urandom), 8'($urandom), 1'($urandom), 7'($urandom),
                     1'($urandom));
      if (!allow_send && it.action == ACT_SEND) it.action = ACT_TICK;
      drive_tick(it);
    end
  endtask

  task automatic random_phase(int n_ticks, bit allow_send, bit with_holdoff);
    int first, kind;
    bit held_off;
    first = ticks_sent;
    held_off = 1'b0;
    while (ticks_sent - first < n_ticks) begin
      if (with_holdoff && !held_off && ticks_sent - first > n_ticks / 4) begin
        hold_req = 1'b1;
        held_off = 1'b1;
      end
      kind = $urandom_range(99);
      if (!allow_send) begin
        if (kind < 50) broken_receive();
        else noise(1'b0);
      end else if (kind < 40) begin
        send_frame();
      end else if (kind < 75) begin
        receive_reply();
      end else if (kind < 88) begin
        noise(1'b1);
      end else begin
        broken_receive();
      end
    end
    settle_link();
    quiesce();
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_TICK;
    in_ch.tx_byte   <= '0;
    in_ch.tx_last   <= 1'b0;
    in_ch.rx_length <= '0;
    in_ch.line_in   <= 1'b1;
    out_ch.ready    <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    rst_n           <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    ticks_sent    = 0;
    quiet         = 0;
    hold_req      = 1'b0;
    inject_on     = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset timings: unused action, back-to-back offers, refused offer and start
    drive_tick(make_item(ACT_TICK, 8'h00, 1'b0, 7'd0, 1'b1));
    drive_tick(make_item(ACT_SPARE, 8'hFF, 1'b1, 7'd127, 1'b0));
    drive_tick(make_item(ACT_SEND, 8'hFF, 1'b0, 7'd0, 1'b1));
    drive_tick(make_item(ACT_SEND, 8'h00, 1'b1, 7'd0, 1'b1));
    drive_tick(make_item(ACT_SEND, 8'hA5, 1'b1, 7'd0, 1'b1));
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd5, 1'b1));
    settle_link();
    quiesce();

    // zero-length phases act as one tick, zero timeout aborts at once
    program_link(16'd0, 16'd0, 16'd0, 20'd0);
    drive_tick(make_item(ACT_SEND, 8'h5A, 1'b0, 7'd0, 1'b1));
    run_line(1'b1, 30);
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd2, 1'b1));
    drive_tick(make_item(ACT_SEND, 8'h81, 1'b1, 7'd0, 1'b1));
    settle_link();
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd3, 1'b1));
    run_line(1'b1, 3);
    settle_link();
    quiesce();

    // saturated length, stop-bit-only reply, refused actions mid-receive
    program_link(16'd1, 16'd2, 16'd1, 20'hFFFFF);
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd127, 1'b1));
    answer(MAX_RX);
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd0, 1'b1));
    run_line(1'b0, 2);
    run_line(1'b1, 2);
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd1, 1'b1));
    drive_tick(make_item(ACT_SEND, 8'h3C, 1'b1, 7'd0, 1'b1));
    drive_tick(make_item(ACT_RECV, 8'h00, 1'b0, 7'd4, 1'b1));
    answer(1);
    settle_link();
    quiesce();

    inject_on = 1'b1;
    program_link(16'd1, 16'd3, 16'd2, 20'd4000);
    random_phase(450, 1'b1, 1'b1);

    src_idle_pct = 77;
    program_link(16'd2, 16'd5, 16'd3, 20'd1500);
    random_phase(350, 1'b1, 1'b0);

    src_idle_pct = 0;
    snk_stall_pct = 77;
    program_link(16'd1, 16'd1, 16'd1, 20'd60);
    random_phase(350, 1'b1, 1'b0);

    src_idle_pct = 17;
    snk_stall_pct = 17;
    program_link(16'($urandom_range(4, 1)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(6, 1)), 20'($urandom_range(3000, 300)));
    random_phase(350, 1'b1, 1'b0);

    // widest timings: receives only, cut short by the timeout
    src_idle_pct = 0;
    snk_stall_pct = 0;
    program_link(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd200);
    random_phase(150, 1'b0, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
